>>> hw/rtl/efl_pkg.sv
`timescale 1ns / 1ps
// efl_pkg: widths, status codes, register indexes and the result record
// shared by the event frame length checker. No dependencies.
package efl_pkg;

  localparam int WORD_W     = 16;
  localparam int LEN_W      = 23;  // record length, word position, counts
  localparam int SUM_W      = 24;  // span sum and next block start
  localparam int SPAN_W     = 17;  // one stored length plus offset
  localparam int LEN_HI_W   = 6;   // length bits carried in word 1
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NON_EVENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OFFSET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENVELOPE = 1'd1;

  localparam logic [SUM_W-1:0] FIRST_BLOCK_POS = 24'd2;
  localparam int               HEADER_WORDS    = 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    event_length;
    logic [LEN_W-1:0]    block_sum;
    logic [LEN_W-1:0]    block_count;
  } result_t;

endpackage

>>> hw/rtl/efl_intf.sv
`timescale 1ns / 1ps
// Channel interfaces of the event frame length checker: word stream,
// result stream and register write port. Depends on efl_pkg.
interface efl_word_if;
  logic                      valid;
  logic                      ready;
  logic [efl_pkg::WORD_W-1:0] word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface efl_result_if;
  logic                         valid;
  logic                         ready;
  logic [efl_pkg::STATUS_W-1:0] status;
  logic [efl_pkg::LEN_W-1:0]    event_length;
  logic [efl_pkg::LEN_W-1:0]    block_sum;
  logic [efl_pkg::LEN_W-1:0]    block_count;
  modport source (output valid, output status, output event_length,
                  output block_sum, output block_count, input ready);
  modport sink (input valid, input status, input event_length,
                input block_sum, input block_count, output ready);
endinterface

interface efl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [efl_pkg::CFG_IDX_W-1:0]  index;
  logic [efl_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/efl_walker.sv
`timescale 1ns / 1ps
// efl_walker: per-record header decode and sub-block walk, one word per
// accepted request; emits a result record on the last word. Uses efl_pkg.
module efl_walker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [efl_pkg::WORD_W-1:0] word,
  input  logic                       header_offset,
  input  logic                       check_envelope,
  output logic                       push,
  output efl_pkg::result_t           result
);

  logic [efl_pkg::LEN_W-1:0]  pos, pos_next;
  logic [efl_pkg::LEN_W-1:0]  rec_len, rec_len_next;
  logic [efl_pkg::SUM_W-1:0]  next_start, next_start_next;
  logic [efl_pkg::SUM_W-1:0]  span_sum, span_sum_next;
  logic [efl_pkg::LEN_W-1:0]  blocks, blocks_next;
  logic                       non_event, non_event_next;
  logic                       zero_span, zero_span_next;

  logic [efl_pkg::SPAN_W-1:0] span;
  logic [efl_pkg::LEN_W-1:0]  len_w1;
  logic                       ne_w1;
  logic [efl_pkg::LEN_W-1:0]  pos_inc;
  logic                       walk;
  logic [efl_pkg::SUM_W-1:0]  sum_w;
  logic [efl_pkg::SUM_W-1:0]  start_w;
  logic [efl_pkg::LEN_W-1:0]  blocks_w;
  logic                       zs_w;
  logic                       done;

  function automatic efl_pkg::result_t make_result(
    input logic [efl_pkg::LEN_W-1:0] len,
    input logic                      ne,
    input logic                      zs,
    input logic [efl_pkg::SUM_W-1:0] sum,
    input logic [efl_pkg::LEN_W-1:0] count
  );
    efl_pkg::result_t          r;
    logic [efl_pkg::LEN_W-1:0] len_m2;
    logic [efl_pkg::SUM_W-1:0] sum_p2;
    len_m2         = len - efl_pkg::LEN_W'(efl_pkg::HEADER_WORDS);
    sum_p2         = sum + efl_pkg::SUM_W'(efl_pkg::HEADER_WORDS);
    r.event_length = len;
    r.block_sum    = '0;
    r.block_count  = '0;
    if (len <= efl_pkg::LEN_W'(1)) begin
      r.status = efl_pkg::STATUS_TOO_SHORT;
    end else if (ne) begin
      r.status = efl_pkg::STATUS_NON_EVENT;
    end else begin
      r.block_sum   = sum_p2[efl_pkg::LEN_W-1:0];
      r.block_count = count;
      if (zs || sum != {1'b0, len_m2}) begin
        r.status = efl_pkg::STATUS_MISMATCH;
      end else begin
        r.status = efl_pkg::STATUS_OK;
      end
    end
    return r;
  endfunction

  // Stored length plus offset: word 0 length and every sub-block span.
  assign span   = {1'b0, word} + efl_pkg::SPAN_W'(header_offset);
  assign len_w1 = rec_len | {1'b0, word[efl_pkg::LEN_HI_W-1:0], 16'b0};
  assign ne_w1  = check_envelope & (|word[efl_pkg::WORD_W-1:efl_pkg::LEN_HI_W]);
  assign pos_inc = pos + efl_pkg::LEN_W'(1);
  assign walk   = !non_event && !zero_span && ({1'b0, pos} == next_start);

  always_comb begin
    sum_w    = span_sum;
    start_w  = next_start;
    blocks_w = blocks;
    zs_w     = zero_span;
    if (walk) begin
      blocks_w = blocks + efl_pkg::LEN_W'(1);
      if (span == '0) begin
        zs_w = 1'b1;
      end else begin
        sum_w   = span_sum + efl_pkg::SUM_W'(span);
        start_w = next_start + efl_pkg::SUM_W'(span);
      end
    end
  end

  always_comb begin
    pos_next        = pos;
    rec_len_next    = rec_len;
    next_start_next = next_start;
    span_sum_next   = span_sum;
    blocks_next     = blocks;
    non_event_next  = non_event;
    zero_span_next  = zero_span;
    done            = 1'b0;
    result          = make_result(rec_len, non_event, zs_w, sum_w, blocks_w);
    if (accept) begin
      if (pos == '0) begin
        rec_len_next = efl_pkg::LEN_W'(span);
        pos_next     = efl_pkg::LEN_W'(1);
      end else if (pos == efl_pkg::LEN_W'(1)) begin
        if (len_w1 <= efl_pkg::LEN_W'(efl_pkg::HEADER_WORDS)) begin
          done   = 1'b1;
          result = make_result(len_w1, ne_w1, zero_span, span_sum, blocks);
        end else begin
          rec_len_next   = len_w1;
          non_event_next = ne_w1;
          pos_next       = efl_pkg::LEN_W'(efl_pkg::HEADER_WORDS);
        end
      end else begin
        if (pos_inc >= rec_len) begin
          done = 1'b1;
        end else begin
          pos_next        = pos_inc;
          span_sum_next   = sum_w;
          next_start_next = start_w;
          blocks_next     = blocks_w;
          zero_span_next  = zs_w;
        end
      end
      // end of record: back to header decode
      if (done) begin
        pos_next        = '0;
        rec_len_next    = '0;
        next_start_next = efl_pkg::FIRST_BLOCK_POS;
        span_sum_next   = '0;
        blocks_next     = '0;
        non_event_next  = 1'b0;
        zero_span_next  = 1'b0;
      end
    end
  end

  assign push = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      rec_len    <= '0;
      next_start <= efl_pkg::FIRST_BLOCK_POS;
      span_sum   <= '0;
      blocks     <= '0;
      non_event  <= 1'b0;
      zero_span  <= 1'b0;
    end else begin
      pos        <= pos_next;
      rec_len    <= rec_len_next;
      next_start <= next_start_next;
      span_sum   <= span_sum_next;
      blocks     <= blocks_next;
      non_event  <= non_event_next;
      zero_span  <= zero_span_next;
    end
  end

endmodule

>>> hw/rtl/efl_out_buf.sv
`timescale 1ns / 1ps
// efl_out_buf: two-entry registered result queue between the walker and
// the result channel. Uses efl_pkg::result_t.
module efl_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  efl_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output efl_pkg::result_t out_data
);

  logic             v0, v0_next, v1, v1_next;
  efl_pkg::result_t d0, d0_next, d1, d1_next;
  logic             pop;

  assign pop = v0 & out_ready;

  always_comb begin
    v0_next = v0;
    v1_next = v1;
    d0_next = d0;
    d1_next = d1;
    if (pop) begin
      v0_next = v1;
      d0_next = d1;
      v1_next = 1'b0;
    end
    if (push) begin
      if (!v0_next) begin
        v0_next = 1'b1;
        d0_next = push_data;
      end else begin
        v1_next = 1'b1;
        d1_next = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    d0 <= d0_next;
    d1 <= d1_next;
  end

  assign full      = v1;
  assign out_valid = v0;
  assign out_data  = d0;

endmodule

>>> hw/rtl/event_frame_length_checker_top.sv
`timescale 1ns / 1ps
// event_frame_length_checker_top: framing check of event records streamed
// as 16-bit words. Depends on efl_pkg, efl_intf, efl_walker, efl_out_buf.
//
//  channel  | dir | payload                                   | one request
//  ---------+-----+-------------------------------------------+--------------------
//  words    | in  | word[15:0]                                | one record word
//  results  | out | status, event_length, block_sum, block_cnt| one per record
//  cfg      | in  | index[0:0], data[0:0]                     | register write
//
//  One word per cycle while words.ready is high. Decode and walk are combinational
//  on each word from the state registers; a result lands in a two-entry output
//  queue the cycle after the record's last word. words.ready drops only while both
//  queue entries hold unread results. cfg.ready is always high. Synchronous reset
//  returns the walker to word 0 and sets header_offset and check_envelope to one.
module event_frame_length_checker_top (
  input logic                clk,
  input logic                rst,
  efl_word_if.sink           words,
  efl_result_if.source       results,
  efl_cfg_if.sink            cfg
);

  // configuration registers
  logic header_offset;
  logic check_envelope;

  logic             accept;
  logic             push;
  logic             full;
  efl_pkg::result_t walk_result;
  efl_pkg::result_t out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_offset  <= 1'b1;
      check_envelope <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        efl_pkg::CFG_HEADER_OFFSET:  header_offset  <= cfg.data[0];
        efl_pkg::CFG_CHECK_ENVELOPE: check_envelope <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // A word is taken whenever the queue has a free slot, so a finished
  // result waiting downstream does not hold up the next record.
  assign words.ready = !full;
  assign accept      = words.valid & words.ready;

  efl_walker u_walker (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .word           (words.word),
    .header_offset  (header_offset),
    .check_envelope (check_envelope),
    .push           (push),
    .result         (walk_result)
  );

  efl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (walk_result),
    .full      (full),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (out_data)
  );

  assign results.status       = out_data.status;
  assign results.event_length = out_data.event_length;
  assign results.block_sum    = out_data.block_sum;
  assign results.block_count  = out_data.block_count;

  // a result is only produced by an accepted word
  a_push_needs_word: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("result produced without an accepted word");

  // an ok record has sub-block spans plus the two header words adding up exactly to the length
  a_ok_sum: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == efl_pkg::STATUS_OK)
      |-> results.block_sum == results.event_length)
    else $error("ok status with block sum differing from length");

  // too short and non-event records carry no walk totals
  a_no_walk_totals: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.status == efl_pkg::STATUS_TOO_SHORT ||
                       results.status == efl_pkg::STATUS_NON_EVENT))
      |-> (results.block_sum == '0 && results.block_count == '0))
    else $error("walk totals reported for an unwalked record");

  // too short means a decoded length of at most one
  a_too_short_len: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == efl_pkg::STATUS_TOO_SHORT)
      |-> results.event_length <= efl_pkg::LEN_W'(1))
    else $error("too short status with a longer record");

endmodule
